### rtl/integer_gcd_lcm_top_macros.svh
// ----------------------------------------------------------------------------
// Integer GCD/LCM assertion macros
// Shared assertion forms for the GCD/LCM block, clocked on clock and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_GCD_LCM_TOP_MACROS_SVH
`define INTEGER_GCD_LCM_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IGL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IGL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/igl_pkg.sv
// ----------------------------------------------------------------------------
// Integer GCD/LCM package
// Word widths, result status codes and shared helpers for the GCD/LCM block.
// ----------------------------------------------------------------------------
package igl_pkg;

   localparam int WIDTH = 32;
   localparam int CNT_W = $clog2(WIDTH);

   typedef logic [WIDTH-1:0]   word_type;
   typedef logic [2*WIDTH-1:0] dword_type;
   typedef logic [CNT_W-1:0]   count_type;

   localparam word_type SIGN_BIT = {1'b1, {(WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_BOTH_ZERO = 2'd2
   } status_type;

   // Magnitude of a two's complement word; the most negative value maps to SIGN_BIT.
   function automatic word_type magnitude_of(input word_type value);
      return value[WIDTH-1] ? word_type'(~value + 1'b1) : value;
   endfunction

endpackage

### rtl/integer_gcd_lcm_top.sv
// Both operands zero skips the Euclid steps and goes straight to the finish state.
// One item at a time; every division runs bit-serially on the shared divider.
// A finished result waits in the output register while the next item is taken.
// Reset is synchronous and active high and clears the sequencer and result valid.
// ----------------------------------------------------------------------------
// Integer GCD/LCM top level
// Euclid GCD of the operand magnitudes and the signed LCM with overflow
// detection, sequenced over a shared iterative divider.
// ----------------------------------------------------------------------------
`include "integer_gcd_lcm_top_macros.svh"

module integer_gcd_lcm_top
   import igl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [WIDTH-1:0] req_first_operand,
   input  logic signed [WIDTH-1:0] req_second_operand,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic        [WIDTH-1:0] rsp_divisor_result,
   output logic signed [WIDTH-1:0] rsp_multiple_result,
   output logic        [1:0]       rsp_status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EUCLID,
      S_REM_WAIT,
      S_QUO_WAIT,
      S_MUL,
      S_CHECK,
      S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   word_type   ma_ff, ma_in;
   word_type   mb_ff, mb_in;
   word_type   x_ff, x_in;
   word_type   y_ff, y_in;
   logic       neg_ff, neg_in;
   dword_type  prod_ff, prod_in;
   word_type   gcd_ff, gcd_in;
   word_type   lcm_ff, lcm_in;
   status_type stat_ff, stat_in;
   logic       rsp_valid_ff, rsp_valid_in;
   word_type   rsp_gcd_ff, rsp_gcd_in;
   word_type   rsp_lcm_ff, rsp_lcm_in;
   status_type rsp_stat_ff, rsp_stat_in;

   logic     div_start;
   word_type div_dividend;
   word_type div_divisor;
   logic     div_done;
   word_type div_quotient;
   word_type div_remainder;
   word_type mag_a;
   word_type mag_b;
   word_type limit;

   igl_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_comb begin
      mag_a        = magnitude_of(word_type'(req_first_operand));
      mag_b        = magnitude_of(word_type'(req_second_operand));
      limit        = neg_ff ? SIGN_BIT : SIGN_BIT - 1'b1;
      state_in     = state_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      gcd_in       = gcd_ff;
      lcm_in       = lcm_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_gcd_in   = rsp_gcd_ff;
      rsp_lcm_in   = rsp_lcm_ff;
      rsp_stat_in  = rsp_stat_ff;
      div_start    = 1'b0;
      div_dividend = x_ff;
      div_divisor  = y_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ma_in  = mag_a;
               mb_in  = mag_b;
               x_in   = mag_a;
               y_in   = mag_b;
               neg_in = req_first_operand[WIDTH-1] ^ req_second_operand[WIDTH-1];
               if (mag_a == '0 && mag_b == '0) begin
                  gcd_in   = '0;
                  lcm_in   = '0;
                  stat_in  = STATUS_BOTH_ZERO;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_EUCLID;
               end
            end
         end
         S_EUCLID: begin
            if (y_ff == '0) begin
               gcd_in = x_ff;
               if (ma_ff == '0 || mb_ff == '0) begin
                  lcm_in   = '0;
                  stat_in  = STATUS_OK;
                  state_in = S_FINISH;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = ma_ff;
                  div_divisor  = x_ff;
                  state_in     = S_QUO_WAIT;
               end
            end else begin
               div_start = 1'b1;
               state_in  = S_REM_WAIT;
            end
         end
         S_REM_WAIT: begin
            if (div_done) begin
               x_in     = y_ff;
               y_in     = div_remainder;
               state_in = S_EUCLID;
            end
         end
         S_QUO_WAIT: begin
            if (div_done) begin
               x_in     = div_quotient;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = dword_type'(x_ff) * dword_type'(mb_ff);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (prod_ff > dword_type'(limit)) begin
               lcm_in  = '0;
               stat_in = STATUS_OVERFLOW;
            end else begin
               lcm_in  = neg_ff ? word_type'(~prod_ff[WIDTH-1:0] + 1'b1) : prod_ff[WIDTH-1:0];
               stat_in = STATUS_OK;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_gcd_in   = gcd_ff;
               rsp_lcm_in   = lcm_ff;
               rsp_stat_in  = stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      gcd_ff      <= gcd_in;
      lcm_ff      <= lcm_in;
      stat_ff     <= stat_in;
      rsp_gcd_ff  <= rsp_gcd_in;
      rsp_lcm_ff  <= rsp_lcm_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_divisor_result  = rsp_gcd_ff;
   assign rsp_multiple_result = rsp_lcm_ff;
   assign rsp_status          = rsp_stat_ff;

   `IGL_ASSERT_NOW(a_done_in_wait, div_done, state_ff == S_REM_WAIT || state_ff == S_QUO_WAIT, "Divider finished outside a wait state.")
   `IGL_ASSERT_NOW(a_overflow_zero, rsp_valid_ff && rsp_stat_ff == STATUS_OVERFLOW, rsp_lcm_ff == '0, "Overflow item carries a nonzero multiple.")
   `IGL_ASSERT_NOW(a_both_zero_gcd, rsp_valid_ff && rsp_stat_ff == STATUS_BOTH_ZERO, rsp_gcd_ff == '0 && rsp_lcm_ff == '0, "Both-zero item carries nonzero results.")

endmodule

### rtl/igl_divider.sv
// ----------------------------------------------------------------------------
// Integer GCD/LCM iterative divider
// Restoring unsigned divider that resolves one quotient bit per cycle and
// is shared by the remainder steps and the final quotient.
// ----------------------------------------------------------------------------
`include "integer_gcd_lcm_top_macros.svh"

module igl_divider
   import igl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type dividend,
   input  word_type divisor,
   output logic     done,
   output word_type quotient,
   output word_type remainder
);

   word_type  rem_ff, rem_in;
   word_type  quo_ff, quo_in;
   word_type  dsr_ff, dsr_in;
   count_type cnt_ff, cnt_in;
   logic      busy_ff, busy_in;
   logic      done_ff, done_in;

   logic [WIDTH:0] shifted;
   logic           fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? word_type'(shifted - {1'b0, dsr_ff}) : shifted[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == count_type'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   `IGL_ASSERT_NOW(a_start_when_idle, start, !busy_ff, "Divider started while busy.")
   `IGL_ASSERT_NEXT(a_start_goes_busy, start, busy_ff && !done_ff, "Divider did not start.")
   `IGL_ASSERT_NOW(a_rem_below_divisor, done_ff, rem_ff < dsr_ff, "Remainder not below divisor.")

endmodule
